// ===== design/tbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsf_pkg
// Shared types, field widths, register indexes and reset values for the
// TDMA burst sync framer.
// ----------------------------------------------------------------------------
package tbsf_pkg;

   // field widths
   localparam int DIBIT_W     = 2;
   localparam int PATTERN_W   = 40;
   localparam int LIMIT_W     = 6;
   localparam int RELOAD_W    = 4;
   localparam int POS_W       = 12;
   localparam int KIND_W      = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_PATTERN = 5;

   typedef logic [DIBIT_W-1:0]   dibit_type;
   typedef logic [PATTERN_W-1:0] pattern_type;
   typedef logic [LIMIT_W-1:0]   limit_type;
   typedef logic [RELOAD_W-1:0]  reload_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes
   localparam csr_idx_type REG_PAT_MAIN     = 3'd0;
   localparam csr_idx_type REG_PAT_REVERSED = 3'd1;
   localparam csr_idx_type REG_PAT_X2400    = 3'd2;
   localparam csr_idx_type REG_PAT_N1200    = 3'd3;
   localparam csr_idx_type REG_PAT_P1200    = 3'd4;
   localparam csr_idx_type REG_ERR_LIMIT    = 3'd5;
   localparam csr_idx_type REG_RELOAD       = 3'd6;

   // sync pattern kinds, in priority order
   localparam kind_type KIND_MAIN     = 3'd0;
   localparam kind_type KIND_REVERSED = 3'd1;
   localparam kind_type KIND_X2400    = 3'd2;
   localparam kind_type KIND_N1200    = 3'd3;
   localparam kind_type KIND_P1200    = 3'd4;

   // register reset values
   localparam pattern_type PAT_MAIN_RESET = 40'd375228200959;
   localparam limit_type   LIMIT_RESET    = 6'd4;
   localparam reload_type  RELOAD_RESET   = 4'd10;

endpackage

// ===== design/tbsf_req_if.sv =====
// ----------------------------------------------------------------------------
// tbsf_req_if
// Input channel: one received dibit per transfer.
// ----------------------------------------------------------------------------
interface tbsf_req_if;
   import tbsf_pkg::*;

   logic      valid;
   logic      ready;
   dibit_type dibit;

   modport source (output valid, output dibit, input ready);
   modport sink   (input valid, input dibit, output ready);
endinterface

// ===== design/tbsf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tbsf_rsp_if
// Result channel: sync report and streamed burst bits, one per transfer.
// ----------------------------------------------------------------------------
interface tbsf_rsp_if;
   import tbsf_pkg::*;

   logic      valid;
   logic      ready;
   logic      sync_found;
   kind_type  sync_kind;
   logic      bit_valid;
   pos_type   bit_position;
   dibit_type body_dibit;
   logic      frame_done;

   modport source (output valid, output sync_found, output sync_kind, output bit_valid,
                   output bit_position, output body_dibit, output frame_done,
                   input ready);
   modport sink   (input valid, input sync_found, input sync_kind, input bit_valid,
                   input bit_position, input body_dibit, input frame_done,
                   output ready);
endinterface

// ===== design/tdma_burst_sync_framer_core.sv =====
// ----------------------------------------------------------------------------
// tdma_burst_sync_framer_core
// Sync window, five-pattern sync detector and burst bit streamer.
//
//   channel   dir  handshake             payload
//   req_chan  in   valid/ready           dibit
//   rsp_chan  out  valid/ready           sync_found, sync_kind, bit_valid,
//                                        bit_position, body_dibit, frame_done
//   csr_*     in   csr_we (no wait)      csr_index, csr_wdata
//
// One dibit per cycle while rsp_chan.ready is high; each result passes
// through the input stage, then the result register. The path in between is
// the error count of the main pattern and the position compare.
// Reset is synchronous; configuration, control and state registers return
// to defaults. With rsp_chan.ready low the result holds, and the input
// backs up once the input stage is also full.
// ----------------------------------------------------------------------------
module tdma_burst_sync_framer_core #(
   parameter int BURST_BITS = 360,
   parameter int SYNC_BITS  = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   tbsf_req_if.sink               req_chan,
   tbsf_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  tbsf_pkg::csr_idx_type  csr_index,
   input  tbsf_pkg::pattern_type  csr_wdata
);
   import tbsf_pkg::*;

   localparam int WIN_W  = SYNC_BITS;
   localparam int GROUPS = (SYNC_BITS + 7) / 8;
   localparam int CNT_W  = $clog2(SYNC_BITS + 1);
   localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [POS_W:0] BURST_END = (POS_W + 1)'(BURST_BITS);
   localparam pos_type        SYNC_POS  = POS_W'(SYNC_BITS);

   // configuration registers
   pattern_type pat_ff [NUM_PATTERN];
   limit_type   limit_ff;
   reload_type  reload_ff;

   // state
   logic [WIN_W-1:0] window_ff, window_in;
   pos_type          pos_ff, pos_in;
   reload_type       frames_ff, frames_in;

   // input stage
   logic      a_valid_ff, a_valid_in;
   dibit_type a_dibit_ff;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      found_ff, found_in;
   kind_type  kind_ff, kind_in;
   logic      bvalid_ff, bvalid_in;
   pos_type   bpos_ff, bpos_in;
   dibit_type body_ff, body_in;
   logic      done_ff, done_in;

   logic out_free, a_free, req_xfer, a_move;

   logic [WIN_W-1:0]      pat_ext [NUM_PATTERN];
   logic [GROUPS*8-1:0]   diff_pad;
   logic [3:0]            grp_cnt [GROUPS];
   logic [CNT_W-1:0]      err_cnt;
   logic                  main_hit, sync_hit;
   kind_type              hit_kind;
   logic [POS_W:0]        pos_nxt;

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign a_free         = !a_valid_ff || out_free;
   assign req_chan.ready = a_free;
   assign req_xfer       = req_chan.valid && a_free;
   assign a_move         = a_valid_ff && out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff[KIND_MAIN]     <= PAT_MAIN_RESET;
         pat_ff[KIND_REVERSED] <= '0;
         pat_ff[KIND_X2400]    <= '0;
         pat_ff[KIND_N1200]    <= '0;
         pat_ff[KIND_P1200]    <= '0;
         limit_ff              <= LIMIT_RESET;
         reload_ff             <= RELOAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_PAT_MAIN:     pat_ff[KIND_MAIN]     <= csr_wdata;
            REG_PAT_REVERSED: pat_ff[KIND_REVERSED] <= csr_wdata;
            REG_PAT_X2400:    pat_ff[KIND_X2400]    <= csr_wdata;
            REG_PAT_N1200:    pat_ff[KIND_N1200]    <= csr_wdata;
            REG_PAT_P1200:    pat_ff[KIND_P1200]    <= csr_wdata;
            REG_ERR_LIMIT:    limit_ff              <= csr_wdata[LIMIT_W-1:0];
            REG_RELOAD:       reload_ff             <= csr_wdata[RELOAD_W-1:0];
            default: ;
         endcase
      end
   end

   // window shift and input stage
   always_comb begin
      window_in  = window_ff;
      a_valid_in = a_valid_ff;
      if (a_free) begin
         a_valid_in = req_chan.valid;
      end
      if (req_xfer) begin
         window_in = {window_ff[WIN_W-3:0], req_chan.dibit};
      end
   end

   // patterns cut to the window width; only their low bits are compared
   always_comb begin
      for (int k = 0; k < NUM_PATTERN; k++) begin
         pat_ext[k] = WIN_W'(pat_ff[k]);
      end
   end

   // main pattern error count: per-byte counts, then their sum
   assign diff_pad = (GROUPS*8)'(window_ff ^ pat_ext[KIND_MAIN]);

   always_comb begin
      err_cnt = '0;
      for (int g = 0; g < GROUPS; g++) begin
         grp_cnt[g] = '0;
         for (int b = 0; b < 8; b++) begin
            grp_cnt[g] = grp_cnt[g] + 4'(diff_pad[g*8+b]);
         end
      end
      for (int g = 0; g < GROUPS; g++) begin
         err_cnt = err_cnt + CNT_W'(grp_cnt[g]);
      end
   end

   assign main_hit = CMP_W'(err_cnt) <= CMP_W'(limit_ff);

   // priority select, lowest kind wins
   always_comb begin
      sync_hit = 1'b1;
      hit_kind = KIND_MAIN;
      if (main_hit) begin
         hit_kind = KIND_MAIN;
      end else if (window_ff == pat_ext[KIND_REVERSED]) begin
         hit_kind = KIND_REVERSED;
      end else if (window_ff == pat_ext[KIND_X2400]) begin
         hit_kind = KIND_X2400;
      end else if (window_ff == pat_ext[KIND_N1200]) begin
         hit_kind = KIND_N1200;
      end else if (window_ff == pat_ext[KIND_P1200]) begin
         hit_kind = KIND_P1200;
      end else begin
         sync_hit = 1'b0;
      end
   end

   // burst framing and result fields
   assign pos_nxt = {1'b0, pos_ff} + (POS_W + 1)'(2);

   always_comb begin
      pos_in    = pos_ff;
      frames_in = frames_ff;
      found_in  = 1'b0;
      kind_in   = KIND_MAIN;
      bvalid_in = 1'b0;
      bpos_in   = '0;
      body_in   = '0;
      done_in   = 1'b0;
      if (sync_hit) begin
         found_in  = 1'b1;
         kind_in   = hit_kind;
         pos_in    = SYNC_POS;
         frames_in = reload_ff;
      end else if (frames_ff != '0) begin
         bvalid_in = 1'b1;
         bpos_in   = pos_ff;
         body_in   = a_dibit_ff;
         if (pos_nxt >= BURST_END) begin
            done_in   = 1'b1;
            frames_in = frames_ff - RELOAD_W'(1);
            pos_in    = '0;
         end else begin
            pos_in = pos_nxt[POS_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = a_valid_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
         pos_ff       <= '0;
         frames_ff    <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         if (a_move) begin
            pos_ff    <= pos_in;
            frames_ff <= frames_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_dibit_ff <= req_chan.dibit;
      end
      if (a_move) begin
         found_ff  <= found_in;
         kind_ff   <= kind_in;
         bvalid_ff <= bvalid_in;
         bpos_ff   <= bpos_in;
         body_ff   <= body_in;
         done_ff   <= done_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sync_found   = found_ff;
   assign rsp_chan.sync_kind    = kind_ff;
   assign rsp_chan.bit_valid    = bvalid_ff;
   assign rsp_chan.bit_position = bpos_ff;
   assign rsp_chan.body_dibit   = body_ff;
   assign rsp_chan.frame_done   = done_ff;

endmodule

// ===== design/tbsf_checker.sv =====
// ----------------------------------------------------------------------------
// tbsf_checker
// Port-level checks for the TDMA burst sync framer, bound to the top level.
// ----------------------------------------------------------------------------
module tbsf_checker #(
   parameter int BURST_BITS = 360
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 sync_found,
   input tbsf_pkg::kind_type   sync_kind,
   input logic                 bit_valid,
   input tbsf_pkg::pos_type    bit_position,
   input tbsf_pkg::dibit_type  body_dibit,
   input logic                 frame_done
);
   import tbsf_pkg::*;

   // no result pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty result register never blocks the input
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sync_found) && $stable(sync_kind)
         && $stable(bit_valid) && $stable(bit_position) && $stable(body_dibit)
         && $stable(frame_done))
      else $error("stalled result changed");

   // end of burst only on a streamed dibit that reaches the burst size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |->
         bit_valid && !sync_found && (32'(bit_position) + 32'd2 >= 32'(BURST_BITS)))
      else $error("frame_done without burst end");

endmodule

bind tdma_burst_sync_framer_core tbsf_checker #(.BURST_BITS(BURST_BITS)) u_tbsf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .sync_found   (rsp_chan.sync_found),
   .sync_kind    (rsp_chan.sync_kind),
   .bit_valid    (rsp_chan.bit_valid),
   .bit_position (rsp_chan.bit_position),
   .body_dibit   (rsp_chan.body_dibit),
   .frame_done   (rsp_chan.frame_done)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tdma_burst_sync_framer_core. A short table of
// dibits runs first, from reset defaults. Then seven register settings
// follow, each with random sync words, near misses, noise and burst bodies.
// Every result transfer is compared with its row's typed-in result if given,
// else with a predictor of the sync window, pattern match and burst position.
// ----------------------------------------------------------------------------
module tb;
   import tbsf_pkg::*;

   localparam int FRAME_BITS    = 360;
   localparam int WINDOW_BITS   = PATTERN_W;
   localparam int SYNC_DIBITS   = WINDOW_BITS / DIBIT_W;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_REPORTS   = 10;

   // index past the end of the register list, writes must be dropped
   localparam csr_idx_type REG_SPARE = 3'd7;

   typedef struct packed {
      logic      sync_found;
      kind_type  sync_kind;
      logic      bit_valid;
      pos_type   bit_position;
      dibit_type body_dibit;
      logic      frame_done;
   } report_type;

   // one stimulus row: the dibit, and a typed-in result where one is given
   typedef struct packed {
      dibit_type  dibit;
      logic       typed;
      report_type report;
   } feed_entry_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   csr_idx_type csr_index;
   pattern_type csr_wdata;

   tbsf_req_if req_bus ();
   tbsf_rsp_if rsp_bus ();

   tdma_burst_sync_framer_core #(
      .BURST_BITS (FRAME_BITS),
      .SYNC_BITS  (WINDOW_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers and the framer state
   pattern_type sync_pat [NUM_PATTERN];
   limit_type   err_limit;
   reload_type  reload_val;
   pattern_type window;
   pos_type     next_pos;
   reload_type  frames_left;

   feed_entry_type dibit_feed [$];
   feed_entry_type offered_rows [$];
   report_type     pending_reports [$];

   int  dibits_sent     = 0;
   int  reports_taken   = 0;
   int  mismatch_count  = 0;
   int  idle_cycles     = 0;
   bit  long_hold_due   = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shift one dibit into the window, match patterns, advance the burst
   function automatic report_type framer_step(dibit_type d);
      report_type  r;
      int unsigned advanced;
      r = '0;
      window = {window[PATTERN_W-DIBIT_W-1:0], d};
      if ($countones(window ^ sync_pat[KIND_MAIN]) <= int'(err_limit)) begin
         r.sync_found = 1'b1;
         r.sync_kind  = KIND_MAIN;
      end else if (window == sync_pat[KIND_REVERSED]) begin
         r.sync_found = 1'b1;
         r.sync_kind  = KIND_REVERSED;
      end else if (window == sync_pat[KIND_X2400]) begin
         r.sync_found = 1'b1;
         r.sync_kind  = KIND_X2400;
      end else if (window == sync_pat[KIND_N1200]) begin
         r.sync_found = 1'b1;
         r.sync_kind  = KIND_N1200;
      end else if (window == sync_pat[KIND_P1200]) begin
         r.sync_found = 1'b1;
         r.sync_kind  = KIND_P1200;
      end
      if (r.sync_found) begin
         next_pos    = pos_type'(WINDOW_BITS);
         frames_left = reload_val;
      end else if (frames_left != '0) begin
         advanced       = next_pos + DIBIT_W;
         r.bit_valid    = 1'b1;
         r.bit_position = next_pos;
         r.body_dibit   = d;
         if (advanced >= FRAME_BITS) begin
            r.frame_done = 1'b1;
            frames_left  = frames_left - 1'b1;
            next_pos     = '0;
         end else begin
            next_pos = pos_type'(advanced);
         end
      end
      return r;
   endfunction

   function automatic string show(report_type r);
      return $sformatf("sync=%0d kind=%0d valid=%0d pos=%0d dibit=%0d done=%0d",
                       r.sync_found, r.sync_kind, r.bit_valid, r.bit_position,
                       r.body_dibit, r.frame_done);
   endfunction

   function automatic pattern_type rand_pattern();
      return pattern_type'({$urandom, $urandom});
   endfunction

   task automatic note_mismatch(string what, report_type want, report_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch (%s) at %0t: want %s | got %s", what, $time, show(want), show(got));
   endtask

   task automatic add_row(dibit_type d, logic typed, report_type r);
      feed_entry_type e;
      e.dibit  = d;
      e.typed  = typed;
      e.report = r;
      dibit_feed.push_back(e);
   endtask

   task automatic push_dibit(dibit_type d);
      add_row(d, 1'b0, '0);
   endtask

   // register write; the predictor copy follows at once, the block is idle
   task automatic write_reg(csr_idx_type idx, pattern_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_PAT_MAIN, REG_PAT_REVERSED, REG_PAT_X2400, REG_PAT_N1200, REG_PAT_P1200:
            sync_pat[idx] = value;
         REG_ERR_LIMIT: err_limit  = value[LIMIT_W-1:0];
         REG_RELOAD:    reload_val = value[RELOAD_W-1:0];
         default: ;
      endcase
   endtask

   // random traffic: mostly sync words followed by burst bodies
   task automatic fill_feed(int count);
      pattern_type word;
      int          pick;
      int          k;
      int          flips;
      int          body_len;
      int          cut;
      while (dibit_feed.size() < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            k    = $urandom_range(0, NUM_PATTERN - 1);
            word = sync_pat[k];
            // main word with bit errors, up to one past the limit
            if (k == KIND_MAIN && $urandom_range(0, 1) == 1) begin
               flips = $urandom_range(0, int'(err_limit) + 1);
               if (flips > PATTERN_W) flips = PATTERN_W;
               repeat (flips) word[$urandom_range(0, PATTERN_W - 1)] ^= 1'b1;
            end
            for (int i = 0; i < SYNC_DIBITS; i++)
               push_dibit(word[PATTERN_W-1-DIBIT_W*i -: DIBIT_W]);
            body_len = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 340)
                                                   : $urandom_range(1, 170);
            repeat (body_len) push_dibit(dibit_type'($urandom_range(0, 3)));
         end else if (pick < 9) begin
            repeat ($urandom_range(1, 30)) push_dibit(dibit_type'($urandom_range(0, 3)));
         end else begin
            // sync word cut short, then one random dibit
            word = sync_pat[$urandom_range(0, NUM_PATTERN - 1)];
            cut  = $urandom_range(1, SYNC_DIBITS - 1);
            for (int i = 0; i < cut; i++)
               push_dibit(word[PATTERN_W-1-DIBIT_W*i -: DIBIT_W]);
            push_dibit(dibit_type'($urandom_range(0, 3)));
         end
      end
   endtask

   // offer the feed in bursts with random gaps
   task automatic play_feed();
      feed_entry_type e;
      int             burst;
      int             gap;
      while (dibit_feed.size() != 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && dibit_feed.size() != 0) begin
            e = dibit_feed.pop_front();
            offered_rows.push_back(e);
            req_bus.valid <= 1'b1;
            req_bus.dibit <= e.dibit;
            do @(posedge clock); while (!req_bus.ready);
            dibits_sent++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid <= 1'b0;
   endtask

   // wait for every result, then let the pipeline settle
   task automatic drain();
      while (reports_taken < dibits_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // transfer monitor: predict on input, compare on output
   always @(posedge clock) begin
      feed_entry_type row;
      report_type     predicted;
      report_type     want;
      report_type     got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            reports_taken++;
            got.sync_found   = rsp_bus.sync_found;
            got.sync_kind    = rsp_bus.sync_kind;
            got.bit_valid    = rsp_bus.bit_valid;
            got.bit_position = rsp_bus.bit_position;
            got.body_dibit   = rsp_bus.body_dibit;
            got.frame_done   = rsp_bus.frame_done;
            if (pending_reports.size() == 0) begin
               note_mismatch("no result due", '0, got);
            end else begin
               want = pending_reports.pop_front();
               if (got !== want) note_mismatch("field", want, got);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            row       = offered_rows.pop_front();
            predicted = framer_step(req_bus.dibit);
            pending_reports.push_back(row.typed ? row.report : predicted);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tdma_burst_sync_framer_core verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: stall patterns of its own, plus one long hold-off
   initial begin : receiver
      rx_mode_type mode;
      int          span;
      rsp_bus.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = rx_mode_type'($urandom_range(0, 3));
            span = $urandom_range(8, 80);
            for (int tick = 0; tick < span; tick++) begin
               case (mode)
                  RX_OPEN:     rsp_bus.ready <= 1'b1;
                  RX_COIN:     rsp_bus.ready <= 1'($urandom_range(0, 1));
                  RX_PERIODIC: rsp_bus.ready <= (tick % 4 != 3);
                  default:     rsp_bus.ready <= ($urandom_range(0, 5) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : main_seq
      report_type  typed_r;
      pattern_type word;
      int          target;

      req_bus.valid <= 1'b0;
      req_bus.dibit <= '0;
      csr_we        <= 1'b0;
      csr_index     <= REG_PAT_MAIN;
      csr_wdata     <= '0;

      // predictor at reset defaults
      sync_pat[KIND_MAIN]     = PAT_MAIN_RESET;
      sync_pat[KIND_REVERSED] = '0;
      sync_pat[KIND_X2400]    = '0;
      sync_pat[KIND_N1200]    = '0;
      sync_pat[KIND_P1200]    = '0;
      err_limit   = LIMIT_RESET;
      reload_val  = RELOAD_RESET;
      window      = '0;
      next_pos    = '0;
      frames_left = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, reset defaults
      // all-zero window hits the zero reversed pattern
      typed_r = '0;
      typed_r.sync_found = 1'b1;
      typed_r.sync_kind  = KIND_REVERSED;
      add_row(2'b00, 1'b1, typed_r);
      // first body dibit lands right after the sync word
      typed_r = '0;
      typed_r.bit_valid    = 1'b1;
      typed_r.bit_position = pos_type'(WINDOW_BITS);
      typed_r.body_dibit   = 2'b11;
      add_row(2'b11, 1'b1, typed_r);
      push_dibit(2'b01);
      // exact main word, last dibit completes the sync
      word = PAT_MAIN_RESET;
      for (int i = 0; i < SYNC_DIBITS - 1; i++)
         push_dibit(word[PATTERN_W-1-DIBIT_W*i -: DIBIT_W]);
      typed_r = '0;
      typed_r.sync_found = 1'b1;
      typed_r.sync_kind  = KIND_MAIN;
      add_row(word[DIBIT_W-1:0], 1'b1, typed_r);
      push_dibit(2'b10);
      push_dibit(2'b00);
      play_feed();
      drain();

      // random part, one register setting per phase
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_PAT_MAIN, rand_pattern());
               write_reg(REG_PAT_REVERSED, rand_pattern());
               write_reg(REG_PAT_X2400, rand_pattern());
               write_reg(REG_PAT_N1200, rand_pattern());
               write_reg(REG_PAT_P1200, rand_pattern());
               write_reg(REG_ERR_LIMIT, pattern_type'($urandom_range(0, 6)));
               write_reg(REG_RELOAD, pattern_type'($urandom_range(2, 15)));
               long_hold_due = 1'b1;
               target = 200;
            end
            1: begin
               // zero reload: a sync streams nothing after it
               write_reg(REG_PAT_MAIN, rand_pattern());
               write_reg(REG_ERR_LIMIT, '0);
               write_reg(REG_RELOAD, '0);
               target = 60;
            end
            2: begin
               // limit of 40: every window is a main sync
               write_reg(REG_ERR_LIMIT, pattern_type'(40));
               write_reg(REG_RELOAD, pattern_type'(15));
               target = 25;
            end
            3: begin
               // all-ones write: limit at its top, upper bits dropped
               write_reg(REG_ERR_LIMIT, '1);
               target = 25;
            end
            4: begin
               // duplicate patterns: lower kind wins
               word = rand_pattern();
               write_reg(REG_PAT_MAIN, word);
               write_reg(REG_PAT_REVERSED, word);
               word = rand_pattern();
               write_reg(REG_PAT_X2400, word);
               write_reg(REG_PAT_N1200, word);
               write_reg(REG_PAT_P1200, word);
               write_reg(REG_ERR_LIMIT, '0);
               write_reg(REG_RELOAD, pattern_type'(1));
               target = 100;
            end
            5: begin
               // pattern extremes, and a write past the register list
               write_reg(REG_PAT_MAIN, '1);
               write_reg(REG_PAT_REVERSED, '0);
               write_reg(REG_PAT_X2400, rand_pattern());
               write_reg(REG_PAT_N1200, rand_pattern());
               write_reg(REG_PAT_P1200, rand_pattern());
               write_reg(REG_ERR_LIMIT, pattern_type'($urandom_range(0, 40)));
               write_reg(REG_RELOAD, pattern_type'(1));
               write_reg(REG_SPARE, rand_pattern());
               target = 100;
            end
            default: begin
               write_reg(REG_PAT_MAIN, rand_pattern());
               write_reg(REG_PAT_REVERSED, rand_pattern());
               write_reg(REG_PAT_X2400, rand_pattern());
               write_reg(REG_PAT_N1200, rand_pattern());
               write_reg(REG_PAT_P1200, rand_pattern());
               write_reg(REG_ERR_LIMIT, pattern_type'($urandom_range(0, 10)));
               write_reg(REG_RELOAD, '1);
               target = 120;
            end
         endcase
         csr_we <= 1'b0;
         fill_feed(target);
         play_feed();
         drain();
      end

      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("tdma_burst_sync_framer_core verification clean");
      end else begin
         $display("tdma_burst_sync_framer_core verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/tbsf_pkg.sv
design/tbsf_req_if.sv
design/tbsf_rsp_if.sv
design/tdma_burst_sync_framer_core.sv
design/tbsf_checker.sv
test/tb.sv
